>>> design/sv39_page_table_walker_assert.svh
// Assertion macros for the Sv39 page table walker.
`ifndef SV39_PAGE_TABLE_WALKER_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SV39_PTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SV39_PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sv39_ptw_pkg.sv
// Package: constants, codes and types of the Sv39 page table walker.
`timescale 1ns / 1ps

package sv39_ptw_pkg;

  localparam int POOL_FRAMES_DEF = 64;
  localparam int PT_ENTRIES      = 512;
  localparam int IDX_W           = 9;
  localparam int PPN_W           = 44;
  localparam int PTE_W           = 54;
  localparam int FLAG_W          = 8;
  localparam int VPN_W           = 27;
  localparam int STATUS_W        = 3;
  localparam int OP_W            = 2;
  localparam int FRAME_OUT_W     = 6;
  localparam int LVL_W           = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP    = 2'd1;
  localparam logic [OP_W-1:0] OP_UNMAP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_FRAMES  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PTR_OUTSIDE = 3'd4;

  localparam logic [LVL_W-1:0] LVL_ROOT = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LEAF = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ALLOC,
    S_DONE
  } state_t;

endpackage

>>> design/sv39_page_table_walker.sv
// Top level: Sv39 page table walker over an internal pool of table frames.
//
// Input channel (in_valid / in_stall) carries one word per request: operation
// (0 lookup, 1 map, 2 unmap; 3 acts as lookup), vpn, target_ppn, perm_flags.
// Output channel (out_valid / out_stall) returns one word per request: status,
// leaf_entry, leaf_frame, leaf_index. Words move when valid is high and stall low.
// cfg_wen / cfg_wdata write table_base_ppn; write only while the block is idle.
// One request is worked at a time; in_stall is high while it is in progress.
// The table store is one memory with one write and one registered read port;
// each level is worked in a read state and then an evaluate state.
// A full walk reads and evaluates each of the three levels, then passes the result
// and idle states before the next request is taken; early stops are shorter.
// Each table created by map adds a clear of all 512 entries of the new frame.
// The result sits in an output register: a stalled receiver holds it there while
// the next request is taken; a new result waits until that register is freed.
// Reset (rst, synchronous): clears all 512 entries of the root frame, in_stall high;
// the allocator restarts at frame 1 and table_base_ppn returns to zero.
`timescale 1ns / 1ps

module sv39_page_table_walker #(
  parameter int POOL_FRAMES = sv39_ptw_pkg::POOL_FRAMES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [sv39_ptw_pkg::PPN_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sv39_ptw_pkg::OP_W-1:0]        operation,
  input  logic [sv39_ptw_pkg::VPN_W-1:0]       vpn,
  input  logic [sv39_ptw_pkg::PPN_W-1:0]       target_ppn,
  input  logic [sv39_ptw_pkg::FLAG_W-1:0]      perm_flags,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sv39_ptw_pkg::STATUS_W-1:0]    status,
  output logic [sv39_ptw_pkg::PTE_W-1:0]       leaf_entry,
  output logic [sv39_ptw_pkg::FRAME_OUT_W-1:0] leaf_frame,
  output logic [sv39_ptw_pkg::IDX_W-1:0]       leaf_index
);

  localparam int FRAME_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int NF_W    = FRAME_W + 1;
  localparam int ADDR_W  = FRAME_W + sv39_ptw_pkg::IDX_W;
  localparam int DEPTH   = POOL_FRAMES * sv39_ptw_pkg::PT_ENTRIES;
  localparam int PPN_W   = sv39_ptw_pkg::PPN_W;
  localparam int PTE_W   = sv39_ptw_pkg::PTE_W;
  localparam int IDX_W   = sv39_ptw_pkg::IDX_W;

  sv39_ptw_pkg::state_t state, state_next;

  logic [PTE_W-1:0]  mem [DEPTH];
  logic [PTE_W-1:0]  rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [PTE_W-1:0]  mem_wdata;

  logic [PPN_W-1:0]                      base;
  logic [NF_W-1:0]                       next_free;
  logic [FRAME_W-1:0]                    frame;
  logic [IDX_W-1:0]                      clr_cnt;
  logic [sv39_ptw_pkg::LVL_W-1:0]        lvl;
  logic [sv39_ptw_pkg::OP_W-1:0]         op_r;
  logic [sv39_ptw_pkg::VPN_W-1:0]        vpn_r;
  logic [PPN_W-1:0]                      tppn_r;
  logic [sv39_ptw_pkg::FLAG_W-1:0]       flags_r;

  logic [sv39_ptw_pkg::STATUS_W-1:0]     res_status;
  logic [PTE_W-1:0]                      res_entry;
  logic [FRAME_W-1:0]                    res_frame;
  logic [IDX_W-1:0]                      res_index;

  logic [IDX_W-1:0]  idx;
  logic              ent_v;
  logic [PPN_W-1:0]  off;
  logic              off_bad;
  logic              pool_full;
  logic              is_leaf;
  logic              is_map;
  logic              out_free;
  logic              clr_last;
  logic [PTE_W-1:0]  ptr_entry;
  logic [PTE_W-1:0]  map_entry;
  logic [FRAME_W+sv39_ptw_pkg::FRAME_OUT_W-1:0] frame_ext;

  always_comb begin
    case (lvl)
      sv39_ptw_pkg::LVL_ROOT: idx = vpn_r[3*IDX_W-1:2*IDX_W];
      sv39_ptw_pkg::LVL_MID:  idx = vpn_r[2*IDX_W-1:IDX_W];
      default:                idx = vpn_r[IDX_W-1:0];
    endcase
  end

  assign ent_v     = rd_data[0];
  assign off       = rd_data[PTE_W-1:10] - base;
  assign off_bad   = off >= PPN_W'(next_free);
  assign pool_full = next_free >= NF_W'(POOL_FRAMES);
  assign is_leaf   = lvl == sv39_ptw_pkg::LVL_LEAF;
  assign is_map    = op_r == sv39_ptw_pkg::OP_MAP;
  assign out_free  = !out_valid || !out_stall;
  assign clr_last  = clr_cnt == IDX_W'(sv39_ptw_pkg::PT_ENTRIES - 1);
  assign ptr_entry = {base + PPN_W'(next_free), 9'b0, 1'b1};
  assign map_entry = {tppn_r, 2'b0, flags_r[7:1], 1'b1};
  assign in_stall  = state != sv39_ptw_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      sv39_ptw_pkg::S_INIT:  if (clr_last) state_next = sv39_ptw_pkg::S_IDLE;
      sv39_ptw_pkg::S_IDLE:  if (in_valid) state_next = sv39_ptw_pkg::S_READ;
      sv39_ptw_pkg::S_READ:  state_next = sv39_ptw_pkg::S_EVAL;
      sv39_ptw_pkg::S_EVAL: begin
        if (is_leaf) begin
          state_next = sv39_ptw_pkg::S_DONE;
        end else if (!ent_v) begin
          state_next = (is_map && !pool_full) ? sv39_ptw_pkg::S_ALLOC : sv39_ptw_pkg::S_DONE;
        end else begin
          state_next = off_bad ? sv39_ptw_pkg::S_DONE : sv39_ptw_pkg::S_READ;
        end
      end
      sv39_ptw_pkg::S_ALLOC: if (clr_last) state_next = sv39_ptw_pkg::S_READ;
      sv39_ptw_pkg::S_DONE:  if (out_free) state_next = sv39_ptw_pkg::S_IDLE;
      default:               state_next = sv39_ptw_pkg::S_INIT;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {frame, idx};
    mem_wdata = '0;
    mem_raddr = {frame, idx};
    case (state)
      sv39_ptw_pkg::S_INIT, sv39_ptw_pkg::S_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = {frame, clr_cnt};
      end
      sv39_ptw_pkg::S_EVAL: begin
        if (is_leaf) begin
          if (is_map && !ent_v) begin
            mem_we    = 1'b1;
            mem_wdata = map_entry;
          end else if (op_r == sv39_ptw_pkg::OP_UNMAP && ent_v) begin
            mem_we    = 1'b1;
          end
        end else if (!ent_v && is_map && !pool_full) begin
          mem_we    = 1'b1;
          mem_wdata = ptr_entry;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sv39_ptw_pkg::S_INIT;
      base      <= '0;
      next_free <= NF_W'(1);
      frame     <= '0;
      clr_cnt   <= '0;
      lvl       <= sv39_ptw_pkg::LVL_ROOT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        base <= cfg_wdata;
      end
      if (state == sv39_ptw_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        sv39_ptw_pkg::S_INIT, sv39_ptw_pkg::S_ALLOC: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        sv39_ptw_pkg::S_IDLE: begin
          if (in_valid) begin
            op_r    <= operation;
            vpn_r   <= vpn;
            tppn_r  <= target_ppn;
            flags_r <= perm_flags;
            frame   <= '0;
            lvl     <= sv39_ptw_pkg::LVL_ROOT;
          end
        end
        sv39_ptw_pkg::S_EVAL: begin
          if (is_leaf) begin
            res_frame <= frame;
            res_index <= idx;
            if (is_map && !ent_v) begin
              res_entry <= map_entry;
            end else if (op_r == sv39_ptw_pkg::OP_UNMAP && ent_v) begin
              res_entry <= '0;
            end else begin
              res_entry <= rd_data;
            end
            if (is_map && ent_v) begin
              res_status <= sv39_ptw_pkg::ST_ALREADY;
            end else if (!is_map && !ent_v) begin
              res_status <= sv39_ptw_pkg::ST_NOT_MAPPED;
            end else begin
              res_status <= sv39_ptw_pkg::ST_OK;
            end
          end else begin
            res_entry <= '0;
            res_frame <= '0;
            res_index <= '0;
            if (!ent_v) begin
              if (!is_map) begin
                res_status <= sv39_ptw_pkg::ST_NOT_MAPPED;
              end else if (pool_full) begin
                res_status <= sv39_ptw_pkg::ST_OUT_FRAMES;
              end else begin
                res_status <= sv39_ptw_pkg::ST_OK;
                frame      <= next_free[FRAME_W-1:0];
                next_free  <= next_free + 1'b1;
                clr_cnt    <= '0;
                lvl        <= lvl + 1'b1;
              end
            end else if (off_bad) begin
              res_status <= sv39_ptw_pkg::ST_PTR_OUTSIDE;
            end else begin
              res_status <= sv39_ptw_pkg::ST_OK;
              frame      <= off[FRAME_W-1:0];
              lvl        <= lvl + 1'b1;
            end
          end
        end
        sv39_ptw_pkg::S_DONE: begin
          if (out_free) begin
            status     <= res_status;
            leaf_entry <= res_entry;
            leaf_frame <= frame_ext[sv39_ptw_pkg::FRAME_OUT_W-1:0];
            leaf_index <= res_index;
          end
        end
        default: clr_cnt <= clr_cnt;
      endcase
    end
  end

  assign frame_ext = {{sv39_ptw_pkg::FRAME_OUT_W{1'b0}}, res_frame};

`include "sv39_page_table_walker_assert.svh"

  `SV39_PTW_ASSERT_NOW(a_next_free_range, 1'b1, next_free != '0 && next_free <= NF_W'(POOL_FRAMES), "allocator count out of range")
  `SV39_PTW_ASSERT_NOW(a_write_when_busy, mem_we, state != sv39_ptw_pkg::S_IDLE && state != sv39_ptw_pkg::S_DONE, "table write outside a walk")
  `SV39_PTW_ASSERT_NEXT(a_alloc_bumps, state == sv39_ptw_pkg::S_EVAL && state_next == sv39_ptw_pkg::S_ALLOC, next_free == NF_W'($past(next_free) + 1'b1), "allocation did not advance the allocator")
  `SV39_PTW_ASSERT_NOW(a_abort_zero, out_valid && (status == sv39_ptw_pkg::ST_OUT_FRAMES || status == sv39_ptw_pkg::ST_PTR_OUTSIDE), leaf_entry == '0 && leaf_frame == '0 && leaf_index == '0, "aborted walk reports leaf fields")

endmodule

>>> sim/testbench.sv
// Testbench for the Sv39 page table walker: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int POOL_FRAMES = sv39_ptw_pkg::POOL_FRAMES_DEF;
  localparam int PT_ENTRIES  = sv39_ptw_pkg::PT_ENTRIES;
  localparam int IDX_W       = sv39_ptw_pkg::IDX_W;
  localparam int PPN_W       = sv39_ptw_pkg::PPN_W;
  localparam int PTE_W       = sv39_ptw_pkg::PTE_W;
  localparam int FLAG_W      = sv39_ptw_pkg::FLAG_W;
  localparam int VPN_W       = sv39_ptw_pkg::VPN_W;
  localparam int STATUS_W    = sv39_ptw_pkg::STATUS_W;
  localparam int OP_W        = sv39_ptw_pkg::OP_W;
  localparam int FRAME_OUT_W = sv39_ptw_pkg::FRAME_OUT_W;
  localparam logic [OP_W-1:0] OP_LOOKUP_ALT = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]    status;
    logic [PTE_W-1:0]       entry;
    logic [FRAME_OUT_W-1:0] frame;
    logic [IDX_W-1:0]       index;
  } walk_reply_t;

  class walk_scoreboard;
    bit [PTE_W-1:0] pool [POOL_FRAMES * PT_ENTRIES];
    int unsigned next_free;
    bit [PPN_W-1:0] base_ppn;
    walk_reply_t awaited [$];
    int unsigned mismatches;
    int unsigned status_seen [8];

    function new();
      next_free = 1;
      base_ppn = '0;
      mismatches = 0;
    endfunction

    // Walks the two upper levels; map creates missing tables.
    function bit [STATUS_W-1:0] descend(input bit [VPN_W-1:0] v, input bit create,
                                        output int unsigned leaf_fr);
      int unsigned fr;
      int unsigned slot;
      int unsigned nf;
      bit [PTE_W-1:0] e;
      bit [PPN_W-1:0] off;
      fr = 0;
      leaf_fr = 0;
      for (int lvl = 0; lvl < 2; lvl++) begin
        slot = fr * PT_ENTRIES + ((v >> (IDX_W * (2 - lvl))) & 511);
        e = pool[slot];
        if (!e[0]) begin
          if (!create) return sv39_ptw_pkg::ST_NOT_MAPPED;
          if (next_free >= POOL_FRAMES) return sv39_ptw_pkg::ST_OUT_FRAMES;
          nf = next_free;
          next_free++;
          for (int k = 0; k < PT_ENTRIES; k++) pool[nf * PT_ENTRIES + k] = '0;
          off = base_ppn + PPN_W'(nf);
          pool[slot] = {off, 10'd1};
          fr = nf;
        end else begin
          off = e[PTE_W-1:10] - base_ppn;
          if (off >= PPN_W'(next_free)) return sv39_ptw_pkg::ST_PTR_OUTSIDE;
          fr = int'(off);
        end
      end
      leaf_fr = fr;
      return sv39_ptw_pkg::ST_OK;
    endfunction

    function void note_request(input bit [OP_W-1:0] op, input bit [VPN_W-1:0] v,
                               input bit [PPN_W-1:0] tppn, input bit [FLAG_W-1:0] flags);
      walk_reply_t r;
      int unsigned fr;
      int unsigned slot;
      bit [PTE_W-1:0] e;
      r.status = descend(v, op == sv39_ptw_pkg::OP_MAP, fr);
      r.entry = '0;
      r.frame = '0;
      r.index = '0;
      if (r.status == sv39_ptw_pkg::ST_OK) begin
        slot = fr * PT_ENTRIES + v[IDX_W-1:0];
        e = pool[slot];
        if (op == sv39_ptw_pkg::OP_MAP) begin
          if (e[0]) r.status = sv39_ptw_pkg::ST_ALREADY;
          else begin
            e = {tppn, 2'b00, flags | 8'h01};
            pool[slot] = e;
          end
        end else if (op == sv39_ptw_pkg::OP_UNMAP) begin
          if (e[0]) begin
            e = '0;
            pool[slot] = '0;
          end else r.status = sv39_ptw_pkg::ST_NOT_MAPPED;
        end else if (!e[0]) r.status = sv39_ptw_pkg::ST_NOT_MAPPED;
        r.entry = e;
        r.frame = fr[FRAME_OUT_W-1:0];
        r.index = v[IDX_W-1:0];
      end
      awaited.push_back(r);
    endfunction

    function void check_reply(input walk_reply_t got);
      walk_reply_t want;
      if (awaited.size() == 0) begin
        $display("%0t: reply with nothing awaited: status %0d entry %h", $time,
                 got.status, got.entry);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.entry !== want.entry) begin
        $display("%0t: leaf_entry expected %h actual %h", $time, want.entry, got.entry);
        mismatches++;
      end
      if (got.frame !== want.frame) begin
        $display("%0t: leaf_frame expected %0d actual %0d", $time, want.frame, got.frame);
        mismatches++;
      end
      if (got.index !== want.index) begin
        $display("%0t: leaf_index expected %0d actual %0d", $time, want.index, got.index);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wen;
  logic [PPN_W-1:0]       cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        operation;
  logic [VPN_W-1:0]       vpn;
  logic [PPN_W-1:0]       target_ppn;
  logic [FLAG_W-1:0]      perm_flags;
  logic                   out_valid;
  logic                   out_stall;
  logic [STATUS_W-1:0]    status;
  logic [PTE_W-1:0]       leaf_entry;
  logic [FRAME_OUT_W-1:0] leaf_frame;
  logic [IDX_W-1:0]       leaf_index;

  walk_scoreboard sb;
  bit calm;
  int unsigned sent;
  bit [IDX_W-1:0] hot_root [3];
  bit [IDX_W-1:0] hot_mid [4];
  bit [IDX_W-1:0] hot_leaf [8];

  sv39_page_table_walker #(.POOL_FRAMES(POOL_FRAMES)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .vpn(vpn),
    .target_ppn(target_ppn),
    .perm_flags(perm_flags),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .leaf_entry(leaf_entry),
    .leaf_frame(leaf_frame),
    .leaf_index(leaf_index)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    walk_reply_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status = status;
        got.entry = leaf_entry;
        got.frame = leaf_frame;
        got.index = leaf_index;
        sb.check_reply(got);
      end
      out_stall <= !calm && ($urandom_range(99) < 11);
    end
  end

  task automatic send_word(input bit [OP_W-1:0] op, input bit [VPN_W-1:0] v,
                           input bit [PPN_W-1:0] tppn, input bit [FLAG_W-1:0] flags);
    in_valid <= 1'b1;
    operation <= op;
    vpn <= v;
    target_ppn <= tppn;
    perm_flags <= flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, v, tppn, flags);
    sent++;
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_table_base(input bit [PPN_W-1:0] b);
    cfg_wen <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.base_ppn = b;
  endtask

  function automatic bit [OP_W-1:0] pick_op();
    int unsigned r = $urandom_range(99);
    if (r < 30) return sv39_ptw_pkg::OP_LOOKUP;
    if (r < 65) return sv39_ptw_pkg::OP_MAP;
    if (r < 90) return sv39_ptw_pkg::OP_UNMAP;
    return OP_LOOKUP_ALT;
  endfunction

  function automatic bit [VPN_W-1:0] pick_vpn();
    int unsigned r = $urandom_range(99);
    bit [31:0] w = $urandom;
    bit [IDX_W-1:0] lo;
    if (r < 10) return w[VPN_W-1:0];
    lo = (r < 70) ? hot_leaf[$urandom_range(7)] : w[IDX_W-1:0];
    return {hot_root[$urandom_range(2)], hot_mid[$urandom_range(3)], lo};
  endfunction

  function automatic bit [PPN_W-1:0] pick_ppn();
    int unsigned r = $urandom_range(9);
    bit [63:0] w = {$urandom, $urandom};
    if (r == 0) return '0;
    if (r == 1) return '1;
    return w[PPN_W-1:0];
  endfunction

  // Mix of single requests and short map/lookup/unmap runs on one address.
  task automatic run_phase(input int unsigned count);
    int unsigned done;
    int unsigned len;
    bit [VPN_W-1:0] v;
    bit [31:0] w;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 30) begin
        v = pick_vpn();
        len = $urandom_range(2, 5);
        for (int k = 0; k < len; k++) begin
          maybe_gap();
          w = $urandom;
          send_word(k == 0 ? sv39_ptw_pkg::OP_MAP : pick_op(), v, pick_ppn(), w[7:0]);
        end
        done += len;
      end else begin
        maybe_gap();
        w = $urandom;
        send_word(pick_op(), pick_vpn(), pick_ppn(), w[7:0]);
        done++;
      end
    end
  endtask

  initial begin
    bit [31:0] w;
    bit [63:0] b;
    sb = new();
    calm = 1'b0;
    sent = 0;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    operation = sv39_ptw_pkg::OP_LOOKUP;
    vpn = '0;
    target_ppn = '0;
    perm_flags = '0;
    out_stall = 1'b0;
    hot_root[0] = 9'd0;
    hot_root[1] = 9'd511;
    hot_mid[0] = 9'd0;
    hot_mid[1] = 9'd511;
    for (int k = 2; k < 4; k++) begin
      w = $urandom;
      hot_mid[k] = w[8:0];
      if (k < 3) hot_root[k] = w[17:9];
    end
    for (int k = 0; k < 8; k++) begin
      w = $urandom;
      hot_leaf[k] = (k == 0) ? 9'd0 : (k == 1) ? 9'd511 : w[8:0];
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_table_base('1);

    // directed: empty root, create, refuse, remove, early stops
    send_word(sv39_ptw_pkg::OP_LOOKUP, 27'd0, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_UNMAP, 27'd0, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_MAP, 27'd0, '1, 8'h00);
    send_word(sv39_ptw_pkg::OP_MAP, 27'd0, '0, 8'hFF);
    send_word(sv39_ptw_pkg::OP_LOOKUP, 27'd0, '0, 8'h00);
    send_word(OP_LOOKUP_ALT, 27'd0, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_MAP, 27'h7FF_FFFF, '0, 8'hFF);
    send_word(sv39_ptw_pkg::OP_LOOKUP, 27'h7FF_FFFF, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_MAP, {9'd0, 9'd0, 9'd511}, 44'hAAA_AAAA_AAAA, 8'hAA);
    send_word(sv39_ptw_pkg::OP_MAP, {9'h155, 9'h0AA, 9'h155}, 44'h555_5555_5555, 8'h55);
    send_word(sv39_ptw_pkg::OP_UNMAP, 27'd0, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_UNMAP, 27'd0, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_LOOKUP, 27'd0, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_LOOKUP, {9'd0, 9'd1, 9'd0}, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_UNMAP, {9'd0, 9'd1, 9'd0}, '0, 8'h00);
    send_word(OP_LOOKUP_ALT, {9'h155, 9'h0AA, 9'h155}, '0, 8'h00);
    send_word(sv39_ptw_pkg::OP_UNMAP, 27'h7FF_FFFF, '0, 8'h00);

    run_phase(300);
    settle();
    set_table_base('0);
    calm = 1'b1;
    run_phase(300);
    settle();
    calm = 1'b0;
    b = {$urandom, $urandom};
    set_table_base(b[PPN_W-1:0]);
    run_phase(200);
    settle();
    set_table_base('1);
    run_phase(300);
    settle();

    $display("Sent %0d requests over four table base settings, with and without idling.",
             sent);
    $display("Replies: ok %0d, not mapped %0d, already %0d, no frames %0d, outside %0d.",
             sb.status_seen[sv39_ptw_pkg::ST_OK],
             sb.status_seen[sv39_ptw_pkg::ST_NOT_MAPPED],
             sb.status_seen[sv39_ptw_pkg::ST_ALREADY],
             sb.status_seen[sv39_ptw_pkg::ST_OUT_FRAMES],
             sb.status_seen[sv39_ptw_pkg::ST_PTR_OUTSIDE]);
    if (sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/sv39_ptw_pkg.sv
design/sv39_page_table_walker.sv
sim/testbench.sv
